[rtl/lmss_pkg.sv]
package lmss_pkg;

  localparam int FRAME_DEPTH    = 256;
  localparam int MATRIX_COLUMNS = 8;
  localparam int ADDR_W         = $clog2(FRAME_DEPTH);
  localparam int COL_W          = $clog2(MATRIX_COLUMNS);
  localparam int BYTE_W         = 8;
  localparam int TICK_W         = 16;
  localparam int OP_W           = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int IN_DATA_W      = 24;
  localparam int OUT_DATA_W     = 32;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_START = 2'd1;
  localparam op_t OP_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_DIR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_PERIOD = 2'd1;

  localparam logic [TICK_W-1:0] PERIOD_RESET = 16'd250;
  localparam logic [ADDR_W-1:0] COLS_ADDR    = ADDR_W'(MATRIX_COLUMNS);

endpackage

[rtl/lmss_ram.sv]
module lmss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/led_matrix_scroll_scanner.sv]
// Start and tick words pass the s1 register, then the output register, to out_tvalid.
// One word per cycle on both channels unless out_tready stalls; writes give no result.
// A frame byte read uses the single read port of the frame store, registered.
// Reset (rst_n low, synchronous) clears counters, window, running flag, pipe valids
// and config registers (direction 0, period 250); the frame store is not cleared.
module led_matrix_scroll_scanner (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // frame_addr, frame_data, frame_length
  input  logic [lmss_pkg::IN_DATA_W-1:0]     in_tdata,
  // op
  input  logic [lmss_pkg::OP_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // column_index, column_select, row_bits, window_start, zero pad
  output logic [lmss_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lmss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import lmss_pkg::*;

  logic                  dir_r;
  logic [TICK_W-1:0]     period_r;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [TICK_W-1:0]     tick_r, tick_nxt, tick_inc;
  logic [ADDR_W-1:0]     win_r, win_nxt, win_scroll;
  logic [ADDR_W-1:0]     last_r, last_nxt;
  logic                  running_r, running_nxt;

  logic                  s1_valid_r;
  logic [COL_W-1:0]      s1_col_r;
  logic [ADDR_W-1:0]     s1_win_r;
  logic [BYTE_W-1:0]     ram_rd_data;

  logic                  out_valid_r;
  logic [COL_W-1:0]      out_col_r;
  logic [MATRIX_COLUMNS-1:0] out_sel_r;
  logic [BYTE_W-1:0]     out_row_r;
  logic [ADDR_W-1:0]     out_win_r;

  op_t                   op;
  logic [ADDR_W-1:0]     frame_addr;
  logic [BYTE_W-1:0]     frame_data;
  logic [BYTE_W-1:0]     frame_length;
  logic [ADDR_W-1:0]     len_sat;
  logic                  in_acc;
  logic                  s1_adv;
  logic                  s1_load;
  logic                  ram_wr;

  assign op           = in_tuser;
  assign frame_addr   = in_tdata[7:0];
  assign frame_data   = in_tdata[15:8];
  assign frame_length = in_tdata[23:16];

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r    <= 1'b0;
      period_r <= PERIOD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SCROLL_DIR:    dir_r    <= cfg_data[0];
        REG_SCROLL_PERIOD: period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // window step with wrap at both frame ends
  always_comb begin
    if (!dir_r) begin
      win_scroll = (win_r >= last_r) ? '0 : win_r + 1'b1;
    end else begin
      win_scroll = (win_r == '0 || win_r > last_r) ? last_r : win_r - 1'b1;
    end
  end

  assign len_sat  = (frame_length < BYTE_W'(MATRIX_COLUMNS)) ? COLS_ADDR : frame_length;
  assign tick_inc = tick_r + 1'b1;

  always_comb begin
    col_nxt     = col_r;
    tick_nxt    = tick_r;
    win_nxt     = win_r;
    last_nxt    = last_r;
    running_nxt = running_r;
    s1_load     = 1'b0;
    ram_wr      = 1'b0;
    if (in_acc) begin
      unique case (op)
        OP_WRITE: ram_wr = 1'b1;
        OP_START: begin
          last_nxt    = len_sat - COLS_ADDR;
          col_nxt     = '0;
          tick_nxt    = '0;
          win_nxt     = dir_r ? len_sat - COLS_ADDR : '0;
          running_nxt = 1'b1;
          s1_load     = 1'b1;
        end
        OP_TICK: begin
          if (running_r) begin
            col_nxt = col_r + 1'b1;
            s1_load = 1'b1;
            if (tick_inc == period_r) begin
              tick_nxt = '0;
              win_nxt  = win_scroll;
            end else begin
              tick_nxt = tick_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      tick_r    <= '0;
      win_r     <= '0;
      last_r    <= '0;
      running_r <= 1'b0;
    end else begin
      col_r     <= col_nxt;
      tick_r    <= tick_nxt;
      win_r     <= win_nxt;
      last_r    <= last_nxt;
      running_r <= running_nxt;
    end
  end

  lmss_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (frame_addr),
    .wr_data (frame_data),
    .rd_en   (s1_load),
    .rd_addr (win_nxt + ADDR_W'(col_nxt)),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= s1_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_col_r <= col_nxt;
      s1_win_r <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_col_r <= s1_col_r;
      out_sel_r <= MATRIX_COLUMNS'(1) << s1_col_r;
      out_row_r <= ram_rd_data;
      out_win_r <= s1_win_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_win_r, out_row_r, out_sel_r, out_col_r};

  a_win_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    win_r <= last_r)
    else $error("window offset past last window position");

  a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (col_r == '0 && tick_r == '0))
    else $error("counters moved before start");

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($onehot(out_sel_r) && out_sel_r[out_col_r]))
    else $error("column select does not match column index");

  a_idle_tick_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == OP_TICK && !running_r) |=> !s1_valid_r)
    else $error("tick before start produced a word");

endmodule

[test/scan_checker.sv]
`timescale 1ns / 1ps
module scan_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [lmss_pkg::IN_DATA_W-1:0]  in_tdata,
  input  lmss_pkg::op_t                   in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [lmss_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lmss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmss_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending
);

  import lmss_pkg::*;

  typedef struct {
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] sel;
    logic [BYTE_W-1:0] row;
    logic [ADDR_W-1:0] win;
  } scan_word_t;

  logic [BYTE_W-1:0] frame_mem [FRAME_DEPTH];
  logic [COL_W-1:0]  col_q;
  logic [TICK_W-1:0] tick_q;
  logic [ADDR_W-1:0] win_q;
  logic [ADDR_W:0]   end_q;
  logic              live_q;
  logic              dir_q;
  logic [TICK_W-1:0] period_q;
  scan_word_t        scan_q [$];

  task automatic report_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= 100)
      $display("%0t: scan word %s: got %0d, want %0d", $time, field, got, want);
  endtask

  function automatic scan_word_t shown_word();
    scan_word_t w;
    w.col = col_q;
    w.sel = BYTE_W'(1) << col_q;
    w.row = frame_mem[win_q + col_q];
    w.win = win_q;
    return w;
  endfunction

  // window wraps at either end of the frame, by the current direction
  task automatic scroll_window();
    logic [ADDR_W:0] last;
    last = end_q - (ADDR_W+1)'(MATRIX_COLUMNS);
    if (!dir_q) begin
      win_q = ({1'b0, win_q} >= last) ? '0 : win_q + 1'b1;
    end else begin
      win_q = (win_q == '0 || {1'b0, win_q} > last) ? last[ADDR_W-1:0] : win_q - 1'b1;
    end
  endtask

  task automatic predict_scan(op_t op, logic [IN_DATA_W-1:0] d);
    logic [ADDR_W:0] len;
    case (op)
      OP_WRITE: frame_mem[d[7:0]] = d[15:8];
      OP_START: begin
        len = {1'b0, d[23:16]};
        if (len < (ADDR_W+1)'(MATRIX_COLUMNS)) len = (ADDR_W+1)'(MATRIX_COLUMNS);
        end_q  = len;
        col_q  = '0;
        tick_q = '0;
        win_q  = dir_q ? ADDR_W'(len - MATRIX_COLUMNS) : '0;
        live_q = 1'b1;
        scan_q.push_back(shown_word());
      end
      OP_TICK: if (live_q) begin
        col_q  = col_q + 1'b1;
        tick_q = tick_q + 1'b1;
        if (tick_q == period_q) begin
          tick_q = '0;
          scroll_window();
        end
        scan_q.push_back(shown_word());
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    scan_word_t want;
    if (!rst_n) begin
      col_q    = '0;
      tick_q   = '0;
      win_q    = '0;
      end_q    = (ADDR_W+1)'(MATRIX_COLUMNS);
      live_q   = 1'b0;
      dir_q    = 1'b0;
      period_q = PERIOD_RESET;
      scan_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SCROLL_DIR) dir_q = cfg_data[0];
        else if (cfg_index == REG_SCROLL_PERIOD) period_q = cfg_data;
      end
      if (out_tvalid && out_tready) begin
        if (scan_q.size() == 0) begin
          report_mismatch("with none queued", int'(out_tdata), -1);
        end else begin
          want = scan_q.pop_front();
          if (out_tdata[2:0] !== want.col)
            report_mismatch("column_index", int'(out_tdata[2:0]), int'(want.col));
          if (out_tdata[10:3] !== want.sel)
            report_mismatch("column_select", int'(out_tdata[10:3]), int'(want.sel));
          if (out_tdata[18:11] !== want.row)
            report_mismatch("row_bits", int'(out_tdata[18:11]), int'(want.row));
          if (out_tdata[26:19] !== want.win)
            report_mismatch("window_start", int'(out_tdata[26:19]), int'(want.win));
        end
      end
      if (in_tvalid && in_tready) predict_scan(in_tuser, in_tdata);
    end
    pending = scan_q.size();
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
module tb;
  import lmss_pkg::*;

  localparam op_t OP_SPARE      = 2'd3;
  localparam int  ITEM_TARGET   = 950;
  localparam int  DRAIN_CYCLES  = 4;
  localparam int  WATCHDOG_LIMIT = 2000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  op_t                   in_tuser   = OP_WRITE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_SCROLL_DIR;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  int                    mismatches;
  int                    pending;

  bit   calm;
  bit   shown;
  int   sent;
  int   quiet;
  bit   written [FRAME_DEPTH];
  logic [7:0] pat [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hAA, 8'h55, 8'h0F, 8'hF0};

  led_matrix_scroll_scanner u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scan_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic push_word(op_t op, logic [7:0] addr, logic [7:0] data, logic [7:0] len);
    calm = (sent >= 300 && sent < 450);
    while (!calm && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {len, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (op == OP_START) shown = 1'b1;
    if (op != OP_SPARE && !(op == OP_TICK && !shown)) sent++;
  endtask

  task automatic tick_word();
    push_word(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic load_byte(logic [7:0] addr, logic [7:0] data);
    push_word(OP_WRITE, addr, data, 8'($urandom));
    written[addr] = 1'b1;
  endtask

  // every column the new frame can show must hold a written byte
  task automatic begin_show(logic [7:0] len);
    int span;
    span = (len < MATRIX_COLUMNS) ? MATRIX_COLUMNS : int'(len);
    for (int i = 0; i < span; i++)
      if (!written[i]) load_byte(8'(i), 8'($urandom));
    push_word(OP_START, 8'($urandom), 8'($urandom), len);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_regs(logic dir, logic [TICK_W-1:0] period);
    settle();
    write_reg(REG_SCROLL_DIR, {15'($urandom), dir});
    write_reg(REG_SCROLL_PERIOD, period);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'($urandom_range(7));
    if (r < 14) return 8'd255;
    if (r < 24) return 8'($urandom_range(8, 255));
    return 8'($urandom_range(8, 24));
  endfunction

  initial begin
    int r;
    int phase;
    logic [TICK_W-1:0] period;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: idle ticks, spare op, short frame, scroll and wrap, direction flip
    set_regs(1'b0, 16'd3);
    tick_word();
    tick_word();
    push_word(OP_SPARE, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 0; i < 8; i++) load_byte(8'(i), pat[i]);
    begin_show(8'd0);
    repeat (3) tick_word();
    begin_show(8'd9);
    repeat (5) tick_word();
    set_regs(1'b1, 16'd2);
    repeat (2) tick_word();
    begin_show(8'd9);
    repeat (2) tick_word();

    phase = 0;
    while (sent < ITEM_TARGET) begin
      r = $urandom_range(9);
      if (phase == 0) period = 16'd1;
      else if (phase == 1) period = 16'hFFFF;
      else if (phase == 2) period = 16'd0;
      else if (r < 6) period = 16'($urandom_range(1, 12));
      else if (r < 8) period = 16'($urandom_range(13, 300));
      else period = 16'($urandom);
      set_regs(1'($urandom), period);
      if (phase == 0) begin_show(8'd255);
      else if ($urandom_range(9) < 7) begin_show(pick_len());
      repeat ($urandom_range(15, 60)) begin
        r = $urandom_range(99);
        if (r < 75) tick_word();
        else if (r < 90) load_byte(8'($urandom), 8'($urandom));
        else if (r < 95) push_word(OP_SPARE, 8'($urandom), 8'($urandom), 8'($urandom));
        else begin_show(pick_len());
      end
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/lmss_pkg.sv
rtl/lmss_ram.sv
rtl/led_matrix_scroll_scanner.sv
test/scan_checker.sv
test/tb.sv
